[design/pdw_pkg.sv]
// Shared types and constants for the polyline distance walker.
`timescale 1ns / 1ps
package pdw_pkg;

  localparam int unsigned FIELD_W = 24;
  localparam int unsigned NORM_W  = 16;

  localparam logic [1:0] CMD_CLEAR    = 2'd0;
  localparam logic [1:0] CMD_APPEND   = 2'd1;
  localparam logic [1:0] CMD_WALK     = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  localparam logic [14:0]        NORM_ONE   = 15'd16384;
  localparam logic [FIELD_W-1:0] OFFSET_MAX = 24'hFFFFFF;

  typedef struct packed {
    logic [1:0]                 command;
    logic signed [FIELD_W-1:0]  coord_x;
    logic signed [FIELD_W-1:0]  coord_y;
    logic [FIELD_W-1:0]         walk_distance;
    logic                       save_position;
  } pdw_in_t;

  typedef struct packed {
    logic                       found;
    logic signed [FIELD_W-1:0]  point_x;
    logic signed [FIELD_W-1:0]  point_y;
    logic signed [NORM_W-1:0]   normal_x;
    logic signed [NORM_W-1:0]   normal_y;
  } pdw_out_t;

endpackage

[design/polyline_distance_walker.sv]
// Polyline distance walker: point store, segment walk sequencer, shared mul/sqrt/div.
// A walk query reads the RAM, does two squarings on the shared multiplier and
// takes one root bit per cycle for each segment walked, then runs the hit
// segment's four rounded divisions, one quotient bit a cycle.
// One word at a time; input ready only while idle. Reset empties the path and
// the saved position; the point store is not cleared.
`timescale 1ns / 1ps
module polyline_distance_walker #(
  parameter int unsigned MAX_POINTS = 256,
  parameter int unsigned COORD_BITS = 24
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pdw_pkg::pdw_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pdw_pkg::pdw_out_t out_data_o
);

  localparam int unsigned ADDRW = $clog2(MAX_POINTS);
  localparam int unsigned CNTW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned AW    = COORD_BITS;
  localparam int unsigned LW    = AW + 1;
  localparam int unsigned SQI   = AW + 1;
  localparam int unsigned RADW  = 2 * SQI;
  localparam int unsigned MBW   = (LW > 15) ? LW : 15;
  localparam int unsigned PW    = AW + MBW;
  localparam int unsigned QW    = ((AW > 15) ? AW : 15) + 1;
  localparam int unsigned ACW   = ((LW > 25) ? LW : 25) + 1;
  localparam int unsigned XW    = ((COORD_BITS > 24) ? COORD_BITS : 24) + 2;
  localparam int unsigned ITMAX = (SQI > QW) ? SQI : QW;
  localparam int unsigned CTW   = $clog2(ITMAX + 1);
  localparam int unsigned ZW    = COORD_BITS + pdw_pkg::FIELD_W;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_RD2  = 4'd3;
  localparam logic [3:0] S_SQX  = 4'd4;
  localparam logic [3:0] S_SQY  = 4'd5;
  localparam logic [3:0] S_SQS  = 4'd6;
  localparam logic [3:0] S_SQRT = 4'd7;
  localparam logic [3:0] S_CMP  = 4'd8;
  localparam logic [3:0] S_MUL  = 4'd9;
  localparam logic [3:0] S_DVS  = 4'd10;
  localparam logic [3:0] S_DIV  = 4'd11;
  localparam logic [3:0] S_RND  = 4'd12;
  localparam logic [3:0] S_EMIT = 4'd13;

  localparam logic [1:0] JOB_PX = 2'd0;
  localparam logic [1:0] JOB_PY = 2'd1;
  localparam logic [1:0] JOB_NX = 2'd2;
  localparam logic [1:0] JOB_NY = 2'd3;

  logic [3:0]              state_q, state_d;
  logic [CNTW-1:0]         count_q, count_d;
  logic [ADDRW-1:0]        seg_q, seg_d;
  logic [23:0]             off_q, off_d;
  logic [ADDRW-1:0]        s_q, s_d;
  logic [ACW-1:0]          acc_q, acc_d;
  logic                    save_q, save_d;
  logic signed [COORD_BITS-1:0] x0_q, x0_d, y0_q, y0_d;
  logic [AW-1:0]           ax_q, ax_d, ay_q, ay_d;
  logic                    negx_q, negx_d, negy_q, negy_d;
  logic [PW-1:0]           prod_q, prod_d, sqr_q, sqr_d;
  logic [RADW-1:0]         rad_q, rad_d;
  logic [LW-1:0]           root_q, root_d;
  logic [LW:0]             srem_q, srem_d;
  logic [CTW-1:0]          cnt_q, cnt_d;
  logic [1:0]              job_q, job_d;
  logic [LW:0]             drem_q, drem_d;
  logic [QW-1:0]           dnum_q, dnum_d, dquo_q, dquo_d;
  logic [QW-1:0]           res_q [4];
  logic                    res_we;
  logic [QW-1:0]           res_val;
  logic                    found_q, found_d;
  logic                    out_valid_q, out_valid_d;
  pdw_pkg::pdw_out_t       out_q, out_d;

  // point store
  logic                    ram_we;
  logic [ADDRW-1:0]        ram_waddr, ram_raddr;
  logic [COORD_BITS-1:0]   wx, wy, rd_x, rd_y;
  logic [ZW-1:0]           zx, zy;

  assign zx = ZW'(in_data_i.coord_x[pdw_pkg::FIELD_W-1:0]);
  assign zy = ZW'(in_data_i.coord_y[pdw_pkg::FIELD_W-1:0]);
  assign wx = zx[COORD_BITS-1:0];
  assign wy = zy[COORD_BITS-1:0];
  assign ram_waddr = count_q[ADDRW-1:0];
  assign ram_raddr = (state_q == S_RD1) ? ADDRW'(s_q + 1'b1) : s_q;

  pdw_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_x (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(wx),
    .raddr_i(ram_raddr), .rdata_o(rd_x)
  );
  pdw_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_POINTS)) u_ram_y (
    .clk_i(clk_i), .we_i(ram_we), .waddr_i(ram_waddr), .wdata_i(wy),
    .raddr_i(ram_raddr), .rdata_o(rd_y)
  );

  // shared multiplier
  logic [AW-1:0]  mul_a;
  logic [MBW-1:0] mul_b;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      S_SQX: begin mul_a = ax_q; mul_b = MBW'(ax_q); end
      S_SQY: begin mul_a = ay_q; mul_b = MBW'(ay_q); end
      S_MUL: begin
        case (job_q)
          JOB_PX:  begin mul_a = ax_q; mul_b = MBW'(acc_q); end
          JOB_PY:  begin mul_a = ay_q; mul_b = MBW'(acc_q); end
          JOB_NX:  begin mul_a = ay_q; mul_b = MBW'(pdw_pkg::NORM_ONE); end
          default: begin mul_a = ax_q; mul_b = MBW'(pdw_pkg::NORM_ONE); end
        endcase
      end
      default: ;
    endcase
  end

  // datapath helpers
  logic signed [COORD_BITS:0] dx, dy;
  logic [LW+2:0] sq_t, sq_trial;
  logic [LW+1:0] dv_t;
  logic          dv_ge;
  logic          can_walk;
  logic [CNTW:0] seg_next2;

  assign dx = (COORD_BITS+1)'($signed(rd_x)) - (COORD_BITS+1)'(x0_q);
  assign dy = (COORD_BITS+1)'($signed(rd_y)) - (COORD_BITS+1)'(y0_q);
  assign sq_t     = {srem_q, rad_q[RADW-1 -: 2]};
  assign sq_trial = {1'b0, root_q, 2'b01};
  assign dv_t  = {drem_q, dnum_q[QW-1]};
  assign dv_ge = dv_t >= (LW+2)'(root_q);
  assign can_walk = (count_q >= CNTW'(2)) &&
                    ((CNTW+1)'(seg_q) + (CNTW+1)'(1) < (CNTW+1)'(count_q));
  assign seg_next2 = (CNTW+1)'(s_q) + (CNTW+1)'(2);

  // result assembly
  logic signed [XW-1:0] px, py;
  logic [15:0] nxm, nym;
  assign px = negx_q ? XW'(x0_q) - $signed(XW'(res_q[JOB_PX]))
                     : XW'(x0_q) + $signed(XW'(res_q[JOB_PX]));
  assign py = negy_q ? XW'(y0_q) - $signed(XW'(res_q[JOB_PY]))
                     : XW'(y0_q) + $signed(XW'(res_q[JOB_PY]));
  assign nxm = {1'b0, res_q[JOB_NX][14:0]};
  assign nym = {1'b0, res_q[JOB_NY][14:0]};

  always_comb begin
    state_d = state_q;   count_d = count_q;  seg_d = seg_q;   off_d = off_q;
    s_d = s_q;           acc_d = acc_q;      save_d = save_q;
    x0_d = x0_q;         y0_d = y0_q;        ax_d = ax_q;     ay_d = ay_q;
    negx_d = negx_q;     negy_d = negy_q;    prod_d = prod_q; sqr_d = sqr_q;
    rad_d = rad_q;       root_d = root_q;    srem_d = srem_q; cnt_d = cnt_q;
    job_d = job_q;       drem_d = drem_q;    dnum_d = dnum_q; dquo_d = dquo_q;
    found_d = found_q;   out_d = out_q;      ram_we = 1'b0;
    res_we = 1'b0;       res_val = '0;
    out_valid_d = out_valid_q & ~out_ready_i;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          case (in_data_i.command)
            pdw_pkg::CMD_CLEAR: begin
              count_d = '0; seg_d = '0; off_d = '0;
            end
            pdw_pkg::CMD_APPEND: begin
              if (count_q < CNTW'(MAX_POINTS)) begin
                ram_we  = 1'b1;
                count_d = count_q + 1'b1;
              end
            end
            pdw_pkg::CMD_WALK: begin
              save_d  = in_data_i.save_position;
              s_d     = seg_q;
              acc_d   = ACW'(in_data_i.walk_distance) + ACW'(off_q);
              found_d = 1'b0;
              state_d = can_walk ? S_RD0 : S_EMIT;
            end
            default: ;
          endcase
        end
      end
      S_RD0: state_d = S_RD1;
      S_RD1: begin
        x0_d = rd_x; y0_d = rd_y;
        state_d = S_RD2;
      end
      S_RD2: begin
        negx_d = dx[COORD_BITS];
        negy_d = dy[COORD_BITS];
        ax_d = dx[COORD_BITS] ? AW'(-dx) : AW'(dx);
        ay_d = dy[COORD_BITS] ? AW'(-dy) : AW'(dy);
        state_d = S_SQX;
      end
      S_SQX: begin
        prod_d = {{MBW{1'b0}}, mul_a} * {{AW{1'b0}}, mul_b};
        state_d = S_SQY;
      end
      S_SQY: begin
        sqr_d  = prod_q;
        prod_d = {{MBW{1'b0}}, mul_a} * {{AW{1'b0}}, mul_b};
        state_d = S_SQS;
      end
      S_SQS: begin
        rad_d  = RADW'(sqr_q) + RADW'(prod_q);
        root_d = '0; srem_d = '0; cnt_d = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        if (sq_t >= sq_trial) begin
          srem_d = (LW+1)'(sq_t - sq_trial);
          root_d = {root_q[LW-2:0], 1'b1};
        end else begin
          srem_d = (LW+1)'(sq_t);
          root_d = {root_q[LW-2:0], 1'b0};
        end
        rad_d = {rad_q[RADW-3:0], 2'b00};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CTW'(SQI - 1)) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // root_q now holds the segment length
        if (acc_q < ACW'(root_q)) begin
          job_d = JOB_PX;
          state_d = S_MUL;
        end else begin
          acc_d = acc_q - ACW'(root_q);
          if (seg_next2 < (CNTW+1)'(count_q)) begin
            s_d = s_q + 1'b1;
            state_d = S_RD0;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_MUL: begin
        prod_d = {{MBW{1'b0}}, mul_a} * {{AW{1'b0}}, mul_b};
        state_d = S_DVS;
      end
      S_DVS: begin
        drem_d = (LW+1)'(prod_q >> QW);
        dnum_d = prod_q[QW-1:0];
        dquo_d = '0; cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        drem_d = dv_ge ? (LW+1)'(dv_t - (LW+2)'(root_q)) : dv_t[LW:0];
        dquo_d = {dquo_q[QW-2:0], dv_ge};
        dnum_d = {dnum_q[QW-2:0], 1'b0};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CTW'(QW - 1)) begin
          state_d = S_RND;
        end
      end
      S_RND: begin
        res_we  = 1'b1;
        res_val = ({drem_q, 1'b0} >= (LW+2)'(root_q)) ? dquo_q + 1'b1 : dquo_q;
        if (job_q == JOB_NY) begin
          found_d = 1'b1;
          state_d = S_EMIT;
        end else begin
          job_d = job_q + 1'b1;
          state_d = S_MUL;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (found_q) begin
            out_d.found    = 1'b1;
            out_d.point_x  = px[23:0];
            out_d.point_y  = py[23:0];
            out_d.normal_x = negy_q ? nxm : 16'(-nxm);
            out_d.normal_y = negx_q ? 16'(-nym) : nym;
            if (save_q) begin
              seg_d = s_q;
              off_d = (acc_q > ACW'(pdw_pkg::OFFSET_MAX)) ? pdw_pkg::OFFSET_MAX
                                                           : acc_q[23:0];
            end
          end else begin
            out_d = '0;
          end
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      seg_q       <= '0;
      off_q       <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      job_q       <= '0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      seg_q       <= seg_d;
      off_q       <= off_d;
      out_valid_q <= out_valid_d;
      found_q     <= found_d;
      job_q       <= job_d;
      cnt_q       <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s_q <= s_d;       acc_q <= acc_d;   save_q <= save_d;
    x0_q <= x0_d;     y0_q <= y0_d;     ax_q <= ax_d;     ay_q <= ay_d;
    negx_q <= negx_d; negy_q <= negy_d; prod_q <= prod_d; sqr_q <= sqr_d;
    rad_q <= rad_d;   root_q <= root_d; srem_q <= srem_d;
    drem_q <= drem_d; dnum_q <= dnum_d; dquo_q <= dquo_d;
    out_q <= out_d;
    if (res_we) begin
      res_q[job_q] <= res_val;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[design/pdw_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module pdw_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[tb/sv/pdw_walk_checker.sv]
// Checker for the polyline distance walker: predicts each walk answer and compares it.
`timescale 1ns / 1ps
module pdw_walk_checker (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_ready_i,
  input  pdw_pkg::pdw_in_t  in_data_i,
  input  logic              out_valid_i,
  input  logic              out_ready_i,
  input  pdw_pkg::pdw_out_t out_data_i,
  output int                errors_o,
  output int                pending_o
);
  import pdw_pkg::*;

  localparam int unsigned PATH_DEPTH = 256;

  longint          path_x [PATH_DEPTH];
  longint          path_y [PATH_DEPTH];
  int unsigned     path_len;
  int unsigned     pos_segment;
  longint          pos_offset;
  pdw_out_t        answer_q [$];
  int              mismatches;

  assign errors_o  = mismatches;
  assign pending_o = answer_q.size();

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unit_component(longint d, longint len);
    longint ad;
    longint mag;
    ad  = (d < 0) ? -d : d;
    mag = (ad * NORM_ONE + len / 2) / len;
    return (d < 0) ? -mag : mag;
  endfunction

  // walks from the saved position; offset counts only in the first segment
  task automatic walk_path(input pdw_in_t w, output pdw_out_t ans);
    longint left, dx, dy, ax, ay, len, start, room, noff, qx, qy;
    bit     first;
    ans   = '0;
    left  = longint'(w.walk_distance);
    first = 1'b1;
    if (path_len < 2 || pos_segment >= path_len - 1) return;
    for (int unsigned s = pos_segment; s + 1 < path_len; s++) begin
      dx    = path_x[s+1] - path_x[s];
      dy    = path_y[s+1] - path_y[s];
      ax    = (dx < 0) ? -dx : dx;
      ay    = (dy < 0) ? -dy : dy;
      len   = longint'(floor_root(longint'(ax * ax + ay * ay)));
      start = first ? pos_offset : 0;
      room  = len - start;
      if (left < room) begin
        noff = left + start;
        qx   = (2 * ax * noff + len) / (2 * len);
        qy   = (2 * ay * noff + len) / (2 * len);
        ans.found    = 1'b1;
        ans.point_x  = FIELD_W'(path_x[s] + ((dx < 0) ? -qx : qx));
        ans.point_y  = FIELD_W'(path_y[s] + ((dy < 0) ? -qy : qy));
        ans.normal_x = NORM_W'(unit_component(-dy, len));
        ans.normal_y = NORM_W'(unit_component(dx, len));
        if (w.save_position) begin
          pos_segment = s;
          pos_offset  = (noff > longint'(OFFSET_MAX)) ? longint'(OFFSET_MAX) : noff;
        end
        return;
      end
      left  -= room;
      first  = 1'b0;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    pdw_out_t ans;
    pdw_out_t want;
    if (!rst_ni) begin
      path_len    = 0;
      pos_segment = 0;
      pos_offset  = 0;
      mismatches  = 0;
      answer_q.delete();
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (answer_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result word %h", $realtime, out_data_i);
        end else begin
          want = answer_q.pop_front();
          if (want.found !== out_data_i.found || want.point_x !== out_data_i.point_x ||
              want.point_y !== out_data_i.point_y || want.normal_x !== out_data_i.normal_x ||
              want.normal_y !== out_data_i.normal_y) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp f=%0d p=(%0d,%0d) n=(%0d,%0d) got f=%0d p=(%0d,%0d) n=(%0d,%0d)",
                       $realtime, want.found, want.point_x, want.point_y, want.normal_x,
                       want.normal_y, out_data_i.found, out_data_i.point_x, out_data_i.point_y,
                       out_data_i.normal_x, out_data_i.normal_y);
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        case (in_data_i.command)
          CMD_CLEAR: begin
            path_len    = 0;
            pos_segment = 0;
            pos_offset  = 0;
          end
          CMD_APPEND: begin
            if (path_len < PATH_DEPTH) begin
              path_x[path_len] = longint'(in_data_i.coord_x);
              path_y[path_len] = longint'(in_data_i.coord_y);
              path_len++;
            end
          end
          CMD_WALK: begin
            walk_path(in_data_i, ans);
            answer_q.insert(answer_q.size(), ans);
          end
          default: ;
        endcase
      end
    end
  end

endmodule

[tb/sv/polyline_distance_walker_tb.sv]
// Testbench top for the polyline distance walker: stimulus, handshake pacing and verdict.
`timescale 1ns / 1ps
module polyline_distance_walker_tb;
  import pdw_pkg::*;

  localparam int NUM_WORDS   = 1450;
  localparam int HOLD_CYCLES = 3000;
  localparam int STALL_LIMIT = 60000;

  logic     clk_i;
  logic     rst_ni;
  logic     in_valid_i;
  logic     in_ready_o;
  pdw_in_t  in_data_i;
  logic     out_valid_o;
  logic     out_ready_i;
  pdw_out_t out_data_o;
  int       errors;
  int       pending;

  int       sent;
  int       snd_idle;
  int       rcv_idle;
  bit       hold_req;
  bit       held;
  int       quiet_cycles;

  polyline_distance_walker i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o)
  );

  pdw_walk_checker i_checker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_i (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_i(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_i (out_data_o),
    .errors_o   (errors),
    .pending_o  (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // receiver pacing, with one long hold-off so the block backs up
  initial begin
    out_ready_i = 1'b0;
    held        = 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !held) begin
        held = 1'b1;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ready_i <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic pdw_in_t make_word(logic [1:0] cmd, int x, int y, int d, bit sv);
    pdw_in_t w;
    w.command       = cmd;
    w.coord_x       = FIELD_W'(x);
    w.coord_y       = FIELD_W'(y);
    w.walk_distance = FIELD_W'(d);
    w.save_position = sv;
    return w;
  endfunction

  task automatic send_word(input pdw_in_t w);
    if ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= w;
    do @(posedge clk_i); while (!in_ready_o);
    sent++;
    if (sent == NUM_WORDS / 3) begin
      snd_idle = 78;
      rcv_idle = 15;
    end else if (sent == 2 * NUM_WORDS / 3) begin
      snd_idle = 0;
      rcv_idle = 0;
      hold_req = 1'b1;
    end
  endtask

  task automatic send_walk(int d, bit sv);
    send_word(make_word(CMD_WALK, $urandom, $urandom, d, sv));
  endtask

  // one random path with a handful of walks on it
  task automatic random_path();
    int n, x, y, walks, span;
    bit wide;
    n = ($urandom_range(99) < 3) ? 260 : $urandom_range(0, 12);
    wide = ($urandom_range(99) < 15);
    if ($urandom_range(99) < 90) send_word(make_word(CMD_CLEAR, $urandom, $urandom, $urandom, 0));
    x = $signed($urandom_range(0, 8000000)) - 4000000;
    y = $signed($urandom_range(0, 8000000)) - 4000000;
    for (int i = 0; i < n; i++) begin
      if (wide) begin
        x = $urandom;
        y = $urandom;
      end else if ($urandom_range(99) < 5) begin
        ;  // repeated point gives a zero-length segment
      end else begin
        x += $signed($urandom_range(0, 4000)) - 2000;
        y += $signed($urandom_range(0, 4000)) - 2000;
      end
      send_word(make_word(CMD_APPEND, x, y, $urandom, $urandom_range(1)));
    end
    walks = (n > 100) ? 4 : $urandom_range(2, 8);
    span  = wide ? 24'hFFFFFF : 1500 * ((n > 1) ? n : 2);
    for (int k = 0; k < walks; k++) begin
      case ($urandom_range(19))
        0, 1:    send_walk(0, $urandom_range(1));
        2, 3:    send_walk($urandom, $urandom_range(1));
        4:       send_word(make_word(CMD_RESERVED, $urandom, $urandom, $urandom,
                                     $urandom_range(1)));
        default: send_walk((n > 100) ? $urandom_range(0, 20000) : $urandom_range(0, span),
                           $urandom_range(1));
      endcase
    end
  endtask

  initial begin
    in_valid_i = 1'b0;
    in_data_i  = '0;
    rst_ni     = 1'b0;
    sent       = 0;
    snd_idle   = 15;
    rcv_idle   = 78;
    hold_req   = 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty path, one point, axis, zero-length and extreme segments
    send_walk(0, 1);
    send_word(make_word(CMD_APPEND, 0, 0, 0, 0));
    send_walk(0, 0);
    send_word(make_word(CMD_APPEND, 2560, 0, 0, 0));
    send_word(make_word(CMD_APPEND, 2560, 0, 0, 0));
    send_word(make_word(CMD_APPEND, 2560, -2560, 0, 0));
    send_walk(0, 0);
    send_walk(2559, 0);
    send_walk(3000, 1);
    send_walk(100, 0);
    send_walk(24'hFFFFFF, 0);
    send_word(make_word(CMD_RESERVED, -1, -1, 24'hFFFFFF, 1));
    send_word(make_word(CMD_CLEAR, 0, 0, 0, 0));
    send_word(make_word(CMD_APPEND, -8388608, -8388608, 0, 0));
    send_word(make_word(CMD_APPEND, 8388607, 8388607, 0, 0));
    send_word(make_word(CMD_APPEND, 8388607, -8388608, 0, 0));
    send_walk(24'hFFFFFF, 1);
    // saved offset goes past 24 bits and saturates
    send_walk(6000000, 1);
    send_walk(0, 0);
    send_walk(24'hFFFFFF, 0);
    send_word(make_word(CMD_CLEAR, 0, 0, 0, 0));
    send_walk(0, 0);

    while (sent < NUM_WORDS) random_path();
    in_valid_i <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
